// ----- hdl/bpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpfa_pkg
// types and constants for the bitmap page frame allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

    localparam int WORD_BITS = 32;
    localparam int WORD_LOG  = 5;

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_TEST    = 2'd2,
        KIND_RESERVE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_TEST_RD,
        S_TEST_CHK,
        S_FILL_RD,
        S_FILL_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                found;
        logic [WORD_LOG-1:0] end_bit;
    } scan_res_t;

endpackage

`default_nettype wire

// ----- hdl/bpfa_if.sv -----
// ----------------------------------------------------------------------------
// bpfa_if
// request and response channels of the allocator
// ----------------------------------------------------------------------------
`default_nettype none

interface bpfa_req_if;
    logic                            valid;
    logic                            ready;
    logic [bpfa_pkg::KIND_W-1:0]     kind;
    logic [bpfa_pkg::INDEX_W-1:0]    block_index;
    logic [bpfa_pkg::COUNT_W-1:0]    count;

    modport source (output valid, kind, block_index, count, input ready);
    modport sink   (input valid, kind, block_index, count, output ready);
endinterface

interface bpfa_resp_if;
    logic                            valid;
    logic                            ready;
    logic [bpfa_pkg::STATUS_W-1:0]   status;
    logic [bpfa_pkg::INDEX_W-1:0]    first_block;
    logic                            is_used;
    logic [bpfa_pkg::COUNT_W-1:0]    used_blocks;

    modport source (output valid, status, first_block, is_used, used_blocks, input ready);
    modport sink   (input valid, status, first_block, is_used, used_blocks, output ready);
endinterface

`default_nettype wire

// ----- hdl/bpfa_map.sv -----
// ----------------------------------------------------------------------------
// bpfa_map
// used-bit map memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_map #(
    parameter int WORDS  = 128,
    parameter int ADDR_W = 7
) (
    input  wire logic                           clk,
    input  wire logic [ADDR_W-1:0]              rd_addr,
    output logic [bpfa_pkg::WORD_BITS-1:0]      rd_data,
    input  wire logic                           wr_en,
    input  wire logic [ADDR_W-1:0]              wr_addr,
    input  wire logic [bpfa_pkg::WORD_BITS-1:0] wr_data
);
    import bpfa_pkg::*;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/bpfa_word_unit.sv -----
// ----------------------------------------------------------------------------
// bpfa_word_unit
// shared word unit: first-fit run search and range mask over one map word
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_word_unit #(
    parameter int CW = 14
) (
    input  wire logic [bpfa_pkg::WORD_BITS-1:0] word,
    input  wire logic [CW-1:0]                  base,
    input  wire logic [CW-1:0]                  run_in,
    input  wire logic [CW-1:0]                  cnt,
    input  wire logic [CW-1:0]                  lo,
    input  wire logic [CW-1:0]                  hi,
    output bpfa_pkg::scan_res_t                 res,
    output logic [CW-1:0]                       run_out,
    output logic [bpfa_pkg::WORD_BITS-1:0]      mask
);
    import bpfa_pkg::*;

    logic [CW-1:0]        run_j [WORD_BITS];
    logic [WORD_BITS-1:0] fit;
    logic [CW-1:0]        pos   [WORD_BITS];

    // run length ending at each bit
    always_comb
    begin
        logic          seen;
        logic [CW-1:0] last;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            seen = 1'b0;
            last = '0;
            for (int k = 0; k <= j; k++)
            begin
                if (word[k])
                begin
                    seen = 1'b1;
                    last = CW'(k);
                end
            end
            if (word[j])
                run_j[j] = '0;
            else if (seen)
                run_j[j] = CW'(j) - last;
            else
                run_j[j] = run_in + CW'(j + 1);
            fit[j] = !word[j] && (run_j[j] >= cnt);
        end
    end

    always_comb
    begin
        res.found   = |fit;
        res.end_bit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (fit[j])
                res.end_bit = WORD_LOG'(j);
        end
        run_out = run_j[WORD_BITS-1];
    end

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            pos[j]  = base + CW'(j);
            mask[j] = (pos[j] >= lo) && (pos[j] < hi);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bitmap_page_frame_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_top
// first-fit bitmap block allocator with free, reserve and test requests
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  req       in   kind, block_index, count
//  resp      out  status, first_block, is_used, used_blocks
//  cfg       in   cfg_we, cfg_data (block_count)
//
//  allocate: scans map words for a first-fit run, then reads and writes each
//  word of the run; free / reserve: reads and writes each word touched; test:
//  reads one word; rejected requests go straight to the response
//  after reset a clearing pass writes every map word, setting the map to ones
//  req is taken only between requests; resp is held in an output register
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_frame_allocator_top #(
    parameter int TOTAL_BLOCKS = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bpfa_pkg::COUNT_W-1:0]  cfg_data,
    bpfa_req_if.sink                           req,
    bpfa_resp_if.source                        resp
);
    import bpfa_pkg::*;

    localparam int MAP_WORDS = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int UTW = $clog2(TOTAL_BLOCKS + 1);
    localparam int CW  = ((UTW > COUNT_W) ? UTW : COUNT_W) + 1;
    localparam int WW  = CW - WORD_LOG;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  block_count_reg;
    logic [UTW-1:0]      used_reg, used_next;
    logic [WA-1:0]       clr_reg, clr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic                val_reg, val_next;
    logic [WW-1:0]       w_reg, w_next;
    logic [WW-1:0]       last_reg, last_next;
    logic [WW-1:0]       pend_reg, pend_next;
    logic                pv_reg, pv_next;
    logic [CW-1:0]       run_reg, run_next;
    logic [WORD_LOG-1:0] bit_reg, bit_next;
    status_t             st_reg, st_next;
    logic [INDEX_W-1:0]  first_reg, first_next;
    logic                isu_reg, isu_next;

    logic                ov_reg, ov_next;
    logic [STATUS_W-1:0] o_status_reg;
    logic [INDEX_W-1:0]  o_first_reg;
    logic                o_used_reg;
    logic [COUNT_W-1:0]  o_blocks_reg;

    logic [WA-1:0]        rd_addr, wr_addr;
    logic [WORD_BITS-1:0] rd_data, wr_data, mask;
    logic                 wr_en;
    logic [CW-1:0]        base, run_out;
    scan_res_t            sres;

    logic [CW-1:0] size, idx_e, cnt_e, bc_e, end_blk, start_blk, sum_add;
    logic [CW-1:0] used_e, cnt_sub;
    logic [WW-1:0] nwords;
    logic          accept, load_out, scan_done;

    bpfa_map #(.WORDS(MAP_WORDS), .ADDR_W(WA)) u_map (
        .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    bpfa_word_unit #(.CW(CW)) u_unit (
        .word(rd_data), .base(base), .run_in(run_reg), .cnt(cnt_reg),
        .lo(lo_reg), .hi(hi_reg), .res(sres), .run_out(run_out), .mask(mask)
    );

    assign bc_e   = CW'(block_count_reg);
    assign size   = ((bc_e > CW'(TOTAL_BLOCKS)) ? CW'(TOTAL_BLOCKS) : bc_e)
                    & ~CW'(WORD_BITS - 1);
    assign nwords = size[CW-1:WORD_LOG];
    assign idx_e  = CW'(req.block_index);
    assign cnt_e  = CW'(req.count);
    assign used_e = CW'(used_reg);
    assign accept = req.valid && req.ready;
    assign load_out = (state_reg == S_DONE) && (!ov_reg || resp.ready);
    assign base   = {((state_reg == S_SCAN) ? pend_reg : w_reg), {WORD_LOG{1'b0}}};
    assign end_blk   = base + CW'(sres.end_bit);
    assign start_blk = end_blk + CW'(1) - cnt_reg;
    assign scan_done = pv_reg && (sres.found || (pend_reg == nwords - WW'(1)));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
                if (clr_reg == WA'(MAP_WORDS - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (accept)
                begin
                    unique case (kind_t'(req.kind))
                        KIND_ALLOC:
                            state_next = (cnt_e == '0 || used_e >= size) ? S_DONE : S_SCAN;
                        KIND_TEST:
                            state_next = (idx_e >= size) ? S_DONE : S_TEST_RD;
                        default:
                            state_next = (idx_e + cnt_e > size || cnt_e == '0)
                                         ? S_DONE : S_FILL_RD;
                    endcase
                end
            S_SCAN:
                if (scan_done)
                    state_next = sres.found ? S_FILL_RD : S_DONE;
            S_TEST_RD:  state_next = S_TEST_CHK;
            S_TEST_CHK: state_next = S_DONE;
            S_FILL_RD:  state_next = S_FILL_WR;
            S_FILL_WR:  state_next = (w_reg == last_reg) ? S_DONE : S_FILL_RD;
            S_DONE:
                if (load_out)
                    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        used_next  = used_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        val_next   = val_reg;
        w_next     = w_reg;
        last_next  = last_reg;
        pend_next  = pend_reg;
        pv_next    = 1'b0;
        run_next   = run_reg;
        bit_next   = bit_reg;
        st_next    = st_reg;
        first_next = first_reg;
        isu_next   = isu_reg;
        ov_next    = ov_reg;
        sum_add    = '0;
        cnt_sub    = '0;
        if (resp.valid && resp.ready)
            ov_next = 1'b0;
        if (load_out)
            ov_next = 1'b1;
        unique case (state_reg)
            S_CLR:
                clr_next = clr_reg + WA'(1);
            S_IDLE:
                if (accept)
                begin
                    st_next    = STAT_OK;
                    first_next = '0;
                    isu_next   = 1'b0;
                    cnt_next   = cnt_e;
                    w_next     = idx_e[CW-1:WORD_LOG];
                    bit_next   = idx_e[WORD_LOG-1:0];
                    lo_next    = idx_e;
                    hi_next    = idx_e + cnt_e;
                    last_next  = WW'((idx_e + cnt_e - CW'(1)) >> WORD_LOG);
                    val_next   = (kind_t'(req.kind) == KIND_RESERVE);
                    unique case (kind_t'(req.kind))
                        KIND_ALLOC:
                        begin
                            st_next  = STAT_NOFIT;
                            w_next   = '0;
                            run_next = '0;
                        end
                        KIND_TEST:
                            if (idx_e >= size)
                                st_next = STAT_RANGE;
                        KIND_FREE:
                            if (idx_e + cnt_e > size)
                                st_next = STAT_RANGE;
                            else
                            begin
                                cnt_sub   = used_e - cnt_e;
                                used_next = (cnt_e > used_e) ? '0 : UTW'(cnt_sub);
                            end
                        default:
                            if (idx_e + cnt_e > size)
                                st_next = STAT_RANGE;
                            else
                            begin
                                sum_add   = used_e + cnt_e;
                                used_next = (sum_add > CW'(TOTAL_BLOCKS))
                                            ? UTW'(TOTAL_BLOCKS) : UTW'(sum_add);
                            end
                    endcase
                end
            S_SCAN:
            begin
                w_next    = w_reg + WW'(1);
                pend_next = w_reg;
                pv_next   = 1'b1;
                if (pv_reg)
                    run_next = run_out;
                if (scan_done && sres.found)
                begin
                    st_next    = STAT_OK;
                    first_next = INDEX_W'(start_blk);
                    lo_next    = start_blk;
                    hi_next    = start_blk + cnt_reg;
                    val_next   = 1'b1;
                    w_next     = start_blk[CW-1:WORD_LOG];
                    last_next  = end_blk[CW-1:WORD_LOG];
                    sum_add    = used_e + cnt_reg;
                    used_next  = (sum_add > CW'(TOTAL_BLOCKS))
                                 ? UTW'(TOTAL_BLOCKS) : UTW'(sum_add);
                end
            end
            S_TEST_CHK:
                isu_next = rd_data[bit_reg];
            S_FILL_WR:
                w_next = w_reg + WW'(1);
            default:
                ;
        endcase
    end

    // memory port and handshake
    always_comb
    begin
        rd_addr = WA'(w_reg);
        wr_addr = WA'(w_reg);
        wr_en   = 1'b0;
        wr_data = val_reg ? (rd_data | mask) : (rd_data & ~mask);
        unique case (state_reg)
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '1;
            end
            S_FILL_WR:
                wr_en = 1'b1;
            default:
                ;
        endcase
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign resp.valid       = ov_reg;
    assign resp.status      = o_status_reg;
    assign resp.first_block = o_first_reg;
    assign resp.is_used     = o_used_reg;
    assign resp.used_blocks = o_blocks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            block_count_reg <= COUNT_W'(TOTAL_BLOCKS);
            used_reg        <= UTW'(TOTAL_BLOCKS);
            clr_reg         <= '0;
            pv_reg          <= 1'b0;
            ov_reg          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                block_count_reg <= cfg_data;
            used_reg  <= used_next;
            clr_reg   <= clr_next;
            pv_reg    <= pv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        val_reg   <= val_next;
        w_reg     <= w_next;
        last_reg  <= last_next;
        pend_reg  <= pend_next;
        run_reg   <= run_next;
        bit_reg   <= bit_next;
        st_reg    <= st_next;
        first_reg <= first_next;
        isu_reg   <= isu_next;
        if (load_out)
        begin
            o_status_reg <= st_reg;
            o_first_reg  <= first_reg;
            o_used_reg   <= isu_reg;
            o_blocks_reg <= COUNT_W'(used_reg);
        end
    end

`ifndef SYNTH
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UTW'(TOTAL_BLOCKS))
        else $error("used count above block total");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken while busy");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid && resp.status != STAT_OK |-> resp.first_block == '0)
        else $error("failed request carries a block");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !wr_en)
        else $error("map written between requests");
`endif

endmodule

`default_nettype wire
